/* rtl/core/smb_pkg.sv */
// Package for the session mailbox slot: opcodes, status and phase codes,
// default widths and the control struct handed from the core to the response buffer.
// No dependencies.
package smb_pkg;

    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF      = 16;
    localparam int SESSION_WIDTH     = 32;

    typedef enum logic [2:0] {
        OP_ENABLE       = 3'd0,
        OP_DISABLE      = 3'd1,
        OP_CONNECT      = 3'd2,
        OP_DISCONNECT   = 3'd3,
        OP_SUBMIT       = 3'd4,
        OP_TAKE_REQUEST = 3'd5,
        OP_COMPLETE     = 3'd6,
        OP_TAKE_REPLY   = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CANCELLED = 2'd1,
        ST_BUSY      = 2'd2,
        ST_REFUSED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_QUEUED  = 2'd1,
        PH_EXEC    = 2'd2,
        PH_REPLIED = 2'd3
    } phase_t;

    typedef struct packed {
        status_t status;
        phase_t  phase;
    } rsp_ctrl_t;

endpackage

/* rtl/core/smb_core.sv */
// Mailbox state and opcode decode: session ownership, slot phase and slot frame.
// Computes one response per accepted transaction. Depends on smb_pkg.
module smb_core
    import smb_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
    parameter int ID_WIDTH      = ID_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [2:0]               opcode,
    input  logic [SESSION_WIDTH-1:0] session_in,
    input  logic [ID_WIDTH-1:0]      frame_id_in,
    input  logic [PAYLOAD_WIDTH-1:0] frame_payload_in,
    output rsp_ctrl_t                rsp_ctrl,
    output logic [SESSION_WIDTH-1:0] rsp_session,
    output logic [ID_WIDTH-1:0]      rsp_frame_id,
    output logic [SESSION_WIDTH-1:0] rsp_frame_session,
    output logic [PAYLOAD_WIDTH-1:0] rsp_frame_payload
);

    logic                     enabled_reg, enabled_next;
    logic [SESSION_WIDTH-1:0] cur_session_reg, cur_session_next;
    logic [SESSION_WIDTH-1:0] last_session_reg, last_session_next;
    phase_t                   phase_reg, phase_next;
    logic [ID_WIDTH-1:0]      slot_id_reg;
    logic [SESSION_WIDTH-1:0] slot_session_reg;
    logic [PAYLOAD_WIDTH-1:0] slot_payload_reg;

    logic                     slot_write;
    logic                     give_frame;
    logic                     connect_op;
    logic [SESSION_WIDTH-1:0] new_session;
    logic [SESSION_WIDTH-1:0] session_inc;
    logic                     session_owned;
    status_t                  status;

    assign session_inc   = last_session_reg + SESSION_WIDTH'(1);
    assign session_owned = (session_in != '0) && (session_in == cur_session_reg);

    always_comb
    begin
        enabled_next      = enabled_reg;
        cur_session_next  = cur_session_reg;
        last_session_next = last_session_reg;
        phase_next        = phase_reg;
        slot_write        = 1'b0;
        give_frame        = 1'b0;
        connect_op        = 1'b0;
        new_session       = '0;
        status            = ST_OK;

        case (opcode_t'(opcode))
            OP_ENABLE:
            begin
                enabled_next = 1'b1;
            end
            OP_DISABLE:
            begin
                enabled_next     = 1'b0;
                cur_session_next = '0;
                if (phase_reg != PH_EXEC)
                    phase_next = PH_IDLE;
            end
            OP_CONNECT:
            begin
                connect_op = 1'b1;
                if (!enabled_reg || cur_session_reg != '0 || phase_reg != PH_IDLE)
                    status = ST_REFUSED;
                else
                begin
                    // skip zero on wrap
                    last_session_next = (session_inc == '0) ? SESSION_WIDTH'(1) : session_inc;
                    cur_session_next  = last_session_next;
                    new_session       = last_session_next;
                end
            end
            OP_DISCONNECT:
            begin
                if (session_owned)
                begin
                    cur_session_next = '0;
                    if (phase_reg != PH_EXEC)
                        phase_next = PH_IDLE;
                end
                else
                    status = ST_REFUSED;
            end
            OP_SUBMIT:
            begin
                if (!enabled_reg || !session_owned)
                    status = ST_CANCELLED;
                else if (phase_reg != PH_IDLE)
                    status = ST_BUSY;
                else
                begin
                    slot_write = 1'b1;
                    phase_next = PH_QUEUED;
                end
            end
            OP_TAKE_REQUEST:
            begin
                if (phase_reg != PH_QUEUED)
                    status = ST_REFUSED;
                else
                begin
                    give_frame = 1'b1;
                    phase_next = PH_EXEC;
                end
            end
            OP_COMPLETE:
            begin
                if (phase_reg != PH_EXEC || slot_id_reg != frame_id_in
                    || slot_session_reg != session_in)
                    status = ST_REFUSED;
                else if (session_in != cur_session_reg)
                begin
                    // owner retired while executing: drop the reply
                    phase_next = PH_IDLE;
                    status     = ST_CANCELLED;
                end
                else
                begin
                    slot_write = 1'b1;
                    phase_next = PH_REPLIED;
                end
            end
            OP_TAKE_REPLY:
            begin
                if (phase_reg != PH_REPLIED || !session_owned)
                    status = ST_REFUSED;
                else
                begin
                    give_frame = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                status = ST_REFUSED;
            end
        endcase
    end

    assign rsp_ctrl.status   = status;
    assign rsp_ctrl.phase    = phase_next;
    assign rsp_session       = connect_op ? new_session : cur_session_next;
    assign rsp_frame_id      = give_frame ? slot_id_reg      : '0;
    assign rsp_frame_session = give_frame ? slot_session_reg : '0;
    assign rsp_frame_payload = give_frame ? slot_payload_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= 1'b0;
            cur_session_reg  <= '0;
            last_session_reg <= '0;
            phase_reg        <= PH_IDLE;
        end
        else if (accept)
        begin
            enabled_reg      <= enabled_next;
            cur_session_reg  <= cur_session_next;
            last_session_reg <= last_session_next;
            phase_reg        <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && slot_write)
        begin
            slot_id_reg      <= frame_id_in;
            slot_session_reg <= session_in;
            slot_payload_reg <= frame_payload_in;
        end
    end

endmodule

/* rtl/core/smb_rsp_fifo.sv */
// Two-entry circular response buffer with write and read pointers, so the core keeps
// accepting while a finished response waits. Depends on smb_pkg.
module smb_rsp_fifo
    import smb_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
    parameter int ID_WIDTH      = ID_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rsp_ctrl_t                push_ctrl,
    input  logic [SESSION_WIDTH-1:0] push_session,
    input  logic [ID_WIDTH-1:0]      push_frame_id,
    input  logic [SESSION_WIDTH-1:0] push_frame_session,
    input  logic [PAYLOAD_WIDTH-1:0] push_frame_payload,
    output logic                     full,
    output logic                     out_valid,
    input  logic                     out_stall,
    output rsp_ctrl_t                out_ctrl,
    output logic [SESSION_WIDTH-1:0] out_session,
    output logic [ID_WIDTH-1:0]      out_frame_id,
    output logic [SESSION_WIDTH-1:0] out_frame_session,
    output logic [PAYLOAD_WIDTH-1:0] out_frame_payload
);

    rsp_ctrl_t                ctrl_reg          [2];
    logic [SESSION_WIDTH-1:0] session_reg       [2];
    logic [ID_WIDTH-1:0]      frame_id_reg      [2];
    logic [SESSION_WIDTH-1:0] frame_session_reg [2];
    logic [PAYLOAD_WIDTH-1:0] frame_payload_reg [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_reg[wr_ptr_reg]          <= push_ctrl;
            session_reg[wr_ptr_reg]       <= push_session;
            frame_id_reg[wr_ptr_reg]      <= push_frame_id;
            frame_session_reg[wr_ptr_reg] <= push_frame_session;
            frame_payload_reg[wr_ptr_reg] <= push_frame_payload;
        end
    end

    assign out_ctrl          = ctrl_reg[rd_ptr_reg];
    assign out_session       = session_reg[rd_ptr_reg];
    assign out_frame_id      = frame_id_reg[rd_ptr_reg];
    assign out_frame_session = frame_session_reg[rd_ptr_reg];
    assign out_frame_payload = frame_payload_reg[rd_ptr_reg];

endmodule

/* rtl/core/session_mailbox_slot.sv */
// Top level of the session mailbox slot: decode core plus response buffer.
// Depends on smb_pkg, smb_core and smb_rsp_fifo.
//
//   Channel   Handshake            Fields
//   request   in_valid / in_stall  opcode, session_in, frame_id_in, frame_payload_in
//   response  out_valid/out_stall  status, session_out, frame_id_out,
//                                  frame_session_out, frame_payload_out, phase_out
//
// One transaction per cycle while in_stall is low; each accepted request yields one
// response, held in the single register stage after the opcode decode.
// Reset clears the session, the enable flag and the slot phase at once.
// A two-entry response buffer absorbs a stall; in_stall rises only when both
// entries hold responses not yet taken.
module session_mailbox_slot
    import smb_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
    parameter int ID_WIDTH      = ID_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               opcode,
    input  logic [SESSION_WIDTH-1:0] session_in,
    input  logic [ID_WIDTH-1:0]      frame_id_in,
    input  logic [PAYLOAD_WIDTH-1:0] frame_payload_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [SESSION_WIDTH-1:0] session_out,
    output logic [ID_WIDTH-1:0]      frame_id_out,
    output logic [SESSION_WIDTH-1:0] frame_session_out,
    output logic [PAYLOAD_WIDTH-1:0] frame_payload_out,
    output logic [1:0]               phase_out
);

    logic                     accept;
    logic                     buf_full;
    rsp_ctrl_t                rsp_ctrl;
    rsp_ctrl_t                out_ctrl;
    logic [SESSION_WIDTH-1:0] rsp_session;
    logic [ID_WIDTH-1:0]      rsp_frame_id;
    logic [SESSION_WIDTH-1:0] rsp_frame_session;
    logic [PAYLOAD_WIDTH-1:0] rsp_frame_payload;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    smb_core #(
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .ID_WIDTH      (ID_WIDTH)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .opcode            (opcode),
        .session_in        (session_in),
        .frame_id_in       (frame_id_in),
        .frame_payload_in  (frame_payload_in),
        .rsp_ctrl          (rsp_ctrl),
        .rsp_session       (rsp_session),
        .rsp_frame_id      (rsp_frame_id),
        .rsp_frame_session (rsp_frame_session),
        .rsp_frame_payload (rsp_frame_payload)
    );

    smb_rsp_fifo #(
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .ID_WIDTH      (ID_WIDTH)
    ) u_rsp_fifo (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (accept),
        .push_ctrl          (rsp_ctrl),
        .push_session       (rsp_session),
        .push_frame_id      (rsp_frame_id),
        .push_frame_session (rsp_frame_session),
        .push_frame_payload (rsp_frame_payload),
        .full               (buf_full),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_ctrl           (out_ctrl),
        .out_session        (session_out),
        .out_frame_id       (frame_id_out),
        .out_frame_session  (frame_session_out),
        .out_frame_payload  (frame_payload_out)
    );

    assign status    = out_ctrl.status;
    assign phase_out = out_ctrl.phase;

endmodule
